// ===== src/gsa_pkg.sv =====
`default_nettype none

package gsa_pkg;

   localparam int SLOTS    = 64;
   localparam int GEN_BITS = 16;
   localparam int IDX_W    = $clog2(SLOTS);
   localparam int CNT_W    = $clog2(SLOTS + 1);

   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [GEN_BITS-1:0] gen_type;
   typedef logic [CNT_W-1:0]    cnt_type;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_FLUSH  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_STALE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_AGEN,
      S_AOUT,
      S_FRD,
      S_FWR,
      S_HOLD
   } fsm_type;

   // generation table port
   typedef struct packed {
      logic    re;
      idx_type raddr;
      logic    we;
      idx_type waddr;
      gen_type wdata;
   } gen_req_type;

   // free stack and pending list ports
   typedef struct packed {
      logic    stack_re;
      idx_type stack_raddr;
      logic    stack_we;
      idx_type stack_waddr;
      idx_type stack_wdata;
      logic    pend_re;
      idx_type pend_raddr;
      logic    pend_we;
      idx_type pend_waddr;
      idx_type pend_wdata;
   } idx_req_type;

   typedef struct packed {
      status_type status;
      idx_type    index;
      gen_type    generation;
      cnt_type    released;
   } result_type;

endpackage

`default_nettype wire

// ===== src/gsa_gen_table.sv =====
`default_nettype none

module gsa_gen_table (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire gsa_pkg::gen_req_type req,
   output gsa_pkg::gen_type          rdata
);
   import gsa_pkg::*;

   gen_type              mem [SLOTS];
   logic [SLOTS-1:0]     valid_ff;
   gen_type              rd_ff;
   logic                 rd_valid_ff;

   // unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (req.we) begin
         valid_ff[req.waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr] <= req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req.re) begin
         rd_ff       <= mem[req.raddr];
         rd_valid_ff <= valid_ff[req.raddr];
      end
   end

   assign rdata = rd_valid_ff ? rd_ff : '0;

endmodule

`default_nettype wire

// ===== src/gsa_index_store.sv =====
`default_nettype none

module gsa_index_store (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire gsa_pkg::idx_req_type req,
   output gsa_pkg::idx_type          stack_rdata,
   output gsa_pkg::idx_type          pend_rdata
);
   import gsa_pkg::*;

   idx_type          stack_mem [SLOTS];
   idx_type          pend_mem  [SLOTS];
   logic [SLOTS-1:0] stack_valid_ff;
   idx_type          stack_rd_ff;
   idx_type          stack_addr_ff;
   logic             stack_rd_valid_ff;
   idx_type          pend_rd_ff;

   // free stack: an entry never written holds its own address
   always_ff @(posedge clock) begin
      if (reset) begin
         stack_valid_ff <= '0;
      end else if (req.stack_we) begin
         stack_valid_ff[req.stack_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req.stack_we) begin
         stack_mem[req.stack_waddr] <= req.stack_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req.stack_re) begin
         stack_rd_ff       <= stack_mem[req.stack_raddr];
         stack_addr_ff     <= req.stack_raddr;
         stack_rd_valid_ff <= stack_valid_ff[req.stack_raddr];
      end
   end

   assign stack_rdata = stack_rd_valid_ff ? stack_rd_ff : stack_addr_ff;

   // pending list: only written entries are ever read
   always_ff @(posedge clock) begin
      if (req.pend_we) begin
         pend_mem[req.pend_waddr] <= req.pend_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req.pend_re) begin
         pend_rd_ff <= pend_mem[req.pend_raddr];
      end
   end

   assign pend_rdata = pend_rd_ff;

endmodule

`default_nettype wire

// ===== src/gsa_ctrl.sv =====
`default_nettype none

module gsa_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire gsa_pkg::op_type       req_op,
   input  wire gsa_pkg::idx_type      req_idx,
   input  wire gsa_pkg::gen_type      req_gen,
   output gsa_pkg::gen_req_type       gen_req,
   input  wire gsa_pkg::gen_type      gen_rdata,
   output gsa_pkg::idx_req_type       idx_req,
   input  wire gsa_pkg::idx_type      stack_rdata,
   input  wire gsa_pkg::idx_type      pend_rdata,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output gsa_pkg::result_type        rsp_result
);
   import gsa_pkg::*;

   fsm_type          state_ff, state_in;
   op_type           op_ff;
   idx_type          idx_ff;
   gen_type          hgen_ff;
   cnt_type          fc_ff;
   cnt_type          pc_ff;
   cnt_type          walk_ff;
   cnt_type          rel_ff;
   idx_type          slot_ff;
   logic [SLOTS-1:0] occ_ff;
   logic [SLOTS-1:0] que_ff;
   result_type       res_ff;
   result_type       out_ff;
   logic             out_vld_ff;

   logic             accept;
   logic             out_free;
   logic             finish;
   logic             walk_done;
   logic             live;
   logic             free_ok;
   logic             push_ok;
   result_type       res_in;

   assign accept    = (state_ff == S_IDLE) && req_valid;
   assign out_free  = !out_vld_ff || rsp_ready;
   assign walk_done = (walk_ff == pc_ff);
   assign live      = occ_ff[idx_ff] && (gen_rdata == hgen_ff);
   assign free_ok   = live && !que_ff[idx_ff] && (pc_ff < CNT_W'(SLOTS));
   assign push_ok   = (fc_ff < CNT_W'(SLOTS));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  OP_ALLOC:  state_in = (fc_ff == '0) ? S_CHECK : S_AGEN;
                  OP_FLUSH:  state_in = S_FRD;
                  default:   state_in = S_CHECK;
               endcase
            end
         end
         S_CHECK: state_in = out_free ? S_IDLE : S_HOLD;
         S_AGEN:  state_in = S_AOUT;
         S_AOUT:  state_in = out_free ? S_IDLE : S_HOLD;
         S_FRD: begin
            if (walk_done) begin
               state_in = out_free ? S_IDLE : S_HOLD;
            end else begin
               state_in = S_FWR;
            end
         end
         S_FWR:   state_in = S_FRD;
         S_HOLD:  state_in = out_free ? S_IDLE : S_HOLD;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs: memory requests and result
   always_comb begin
      req_ready = (state_ff == S_IDLE);
      gen_req   = '0;
      idx_req   = '0;
      finish    = 1'b0;
      res_in    = '{status: STS_OK, index: idx_ff, generation: '0, released: '0};
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_ALLOC) begin
                  idx_req.stack_re    = 1'b1;
                  idx_req.stack_raddr = idx_type'(fc_ff - cnt_type'(1));
               end else begin
                  gen_req.re    = 1'b1;
                  gen_req.raddr = req_idx;
               end
            end
         end
         S_CHECK: begin
            finish = 1'b1;
            case (op_ff)
               OP_ALLOC: begin
                  res_in.status = STS_FULL;
               end
               OP_FREE: begin
                  if (free_ok) begin
                     gen_req.we         = 1'b1;
                     gen_req.waddr      = idx_ff;
                     gen_req.wdata      = gen_rdata + gen_type'(1);
                     idx_req.pend_we    = 1'b1;
                     idx_req.pend_waddr = pc_ff[IDX_W-1:0];
                     idx_req.pend_wdata = idx_ff;
                  end else begin
                     res_in.status = STS_STALE;
                  end
               end
               OP_LOOKUP: begin
                  if (live) begin
                     res_in.generation = gen_rdata;
                  end else begin
                     res_in.status = STS_STALE;
                  end
               end
               default: begin
               end
            endcase
         end
         S_AGEN: begin
            gen_req.re    = 1'b1;
            gen_req.raddr = stack_rdata;
         end
         S_AOUT: begin
            finish            = 1'b1;
            res_in.index      = slot_ff;
            res_in.generation = gen_rdata;
         end
         S_FRD: begin
            if (walk_done) begin
               finish          = 1'b1;
               res_in.released = rel_ff;
            end else begin
               idx_req.pend_re    = 1'b1;
               idx_req.pend_raddr = walk_ff[IDX_W-1:0];
            end
         end
         S_FWR: begin
            if (push_ok) begin
               idx_req.stack_we    = 1'b1;
               idx_req.stack_waddr = fc_ff[IDX_W-1:0];
               idx_req.stack_wdata = pend_rdata;
            end
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         fc_ff      <= CNT_W'(SLOTS);
         pc_ff      <= '0;
         occ_ff     <= '0;
         que_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            S_AGEN: begin
               occ_ff[stack_rdata] <= 1'b1;
               que_ff[stack_rdata] <= 1'b0;
               fc_ff               <= fc_ff - cnt_type'(1);
            end
            S_CHECK: begin
               if ((op_ff == OP_FREE) && free_ok) begin
                  que_ff[idx_ff] <= 1'b1;
                  pc_ff          <= pc_ff + cnt_type'(1);
               end
            end
            S_FRD: begin
               if (walk_done) begin
                  pc_ff <= '0;
               end
            end
            S_FWR: begin
               occ_ff[pend_rdata] <= 1'b0;
               que_ff[pend_rdata] <= 1'b0;
               if (push_ok) begin
                  fc_ff <= fc_ff + cnt_type'(1);
               end
            end
            default: begin
            end
         endcase
         if ((finish || (state_ff == S_HOLD)) && out_free) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // payload and walk registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_op;
         idx_ff  <= req_idx;
         hgen_ff <= req_gen;
         walk_ff <= '0;
         rel_ff  <= '0;
      end
      if (state_ff == S_AGEN) begin
         slot_ff <= stack_rdata;
      end
      if ((state_ff == S_FRD) && !walk_done) begin
         walk_ff <= walk_ff + cnt_type'(1);
      end
      if ((state_ff == S_FWR) && push_ok) begin
         rel_ff <= rel_ff + cnt_type'(1);
      end
      if (finish) begin
         if (out_free) begin
            out_ff <= res_in;
         end else begin
            res_ff <= res_in;
         end
      end else if ((state_ff == S_HOLD) && out_free) begin
         out_ff <= res_ff;
      end
   end

   assign rsp_valid  = out_vld_ff;
   assign rsp_result = out_ff;

endmodule

`default_nettype wire

// ===== src/generational_slot_allocator_core.sv =====
`default_nettype none

// Channel   Dir  Handshake                 tuser              tdata
// req       in   req_tvalid / req_tready   operation [1:0]    handle_index, handle_generation
// rsp       out  rsp_tvalid / rsp_tready   status [1:0]       slot_index, slot_generation,
//                                                             released_count
//
// Lookup and free read the generation, then check it; allocate reads the free
// stack, then the generation it addresses, or reports full when no slot is free;
// flush does a pending list read, then a free stack write, per queued slot.
// Reset is synchronous; counts, occupied/queued marks and RAM valid bits clear
// at once, so there is no clearing pass.
// One result sits in the output register while the next transfer is accepted
// and worked; a finished result waits in a hold register if rsp is stalled.

module generational_slot_allocator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // [1:0] operation
   input  wire logic [23:0] req_tdata,   // [5:0] handle_index, [21:6] handle_generation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [1:0]       rsp_tuser,   // [1:0] status
   output logic [31:0]      rsp_tdata    // [5:0] slot_index, [21:6] slot_generation,
                                         // [28:22] released_count
);
   import gsa_pkg::*;

   gen_req_type gen_req;
   idx_req_type idx_req;
   gen_type     gen_rdata;
   idx_type     stack_rdata;
   idx_type     pend_rdata;
   result_type  result;
   idx_type     req_idx;
   gen_type     req_gen;

   assign req_idx = req_tdata[IDX_W-1:0];
   assign req_gen = req_tdata[IDX_W +: GEN_BITS];

   // sequencer, marks, counts and output register
   gsa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (op_type'(req_tuser)),
      .req_idx     (req_idx),
      .req_gen     (req_gen),
      .gen_req     (gen_req),
      .gen_rdata   (gen_rdata),
      .idx_req     (idx_req),
      .stack_rdata (stack_rdata),
      .pend_rdata  (pend_rdata),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_result  (result)
   );

   // per-slot generation tags
   gsa_gen_table u_gen (
      .clock (clock),
      .reset (reset),
      .req   (gen_req),
      .rdata (gen_rdata)
   );

   // free stack and deferred-release list
   gsa_index_store u_idx (
      .clock       (clock),
      .reset       (reset),
      .req         (idx_req),
      .stack_rdata (stack_rdata),
      .pend_rdata  (pend_rdata)
   );

   assign rsp_tuser = result.status;
   assign rsp_tdata = 32'({result.released, result.generation, result.index});

endmodule

`default_nettype wire

// ===== src/gsa_checker.sv =====
`default_nettype none

module gsa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [1:0]  rsp_tuser,
   input wire logic [31:0] rsp_tdata
);
   import gsa_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STS_OK) || (rsp_tuser == STS_FULL) ||
                     (rsp_tuser == STS_STALE))
      else $error("unknown status");

   // failed transfers carry no generation and no release count
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STS_OK) |-> (rsp_tdata[31:IDX_W] == '0))
      else $error("failed result carries payload");

   a_released_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[28:22] <= 7'(SLOTS)))
      else $error("release count above slot count");

endmodule

bind generational_slot_allocator_core gsa_checker u_gsa_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
